FILE: src/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and codes for the circular list with cursor block.
// ----------------------------------------------------------------------------
`default_nettype none

package clc_pkg;

   // operation codes carried in the request mode field
   localparam logic [2:0] MODE_NEXT       = 3'd0;
   localparam logic [2:0] MODE_PREV       = 3'd1;
   localparam logic [2:0] MODE_INS_AFTER  = 3'd2;
   localparam logic [2:0] MODE_INS_BEFORE = 3'd3;
   localparam logic [2:0] MODE_DEL_NEXT   = 3'd4;
   localparam logic [2:0] MODE_DEL_PREV   = 3'd5;

   // response status codes
   localparam logic [1:0] RSP_DONE  = 2'd0;
   localparam logic [1:0] RSP_EMPTY = 2'd1;
   localparam logic [1:0] RSP_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               cursor_valid;
      logic signed [31:0] cursor_value;
      logic [8:0]         count;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_MOVE,
      DP_POP,
      DP_INS_A,
      DP_INS_B,
      DP_DEL_ONE,
      DP_DEL,
      DP_READ,
      DP_LOAD,
      DP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       nonempty;
      logic       full;
      logic       single;
   } sts_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_INS_A,
      CS_INS_B,
      CS_READ,
      CS_LOAD,
      CS_RESP
   } ctl_state_type;

endpackage

`default_nettype wire

FILE: src/clc_ctrl.sv
// ----------------------------------------------------------------------------
// clc_ctrl
// Sequencer: decodes each transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module clc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire clc_pkg::sts_type sts,
   output clc_pkg::cmd_type      cmd
);
   import clc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic [1:0]    code_ff, code_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         code_ff      <= RSP_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = DP_NOP;
      cmd.code     = code_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_CAPTURE;
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            code_in = RSP_DONE;
            unique case (sts.mode)
               MODE_NEXT, MODE_PREV: begin
                  if (!sts.nonempty) begin
                     code_in  = RSP_EMPTY;
                     state_in = CS_RESP;
                  end else begin
                     cmd.op   = DP_MOVE;
                     state_in = CS_LOAD;
                  end
               end
               MODE_INS_AFTER, MODE_INS_BEFORE: begin
                  if (sts.full) begin
                     code_in  = RSP_FULL;
                     state_in = CS_RESP;
                  end else begin
                     cmd.op   = DP_POP;
                     state_in = CS_INS_A;
                  end
               end
               MODE_DEL_NEXT, MODE_DEL_PREV: begin
                  if (!sts.nonempty) begin
                     code_in  = RSP_EMPTY;
                     state_in = CS_RESP;
                  end else if (sts.single) begin
                     cmd.op   = DP_DEL_ONE;
                     state_in = CS_RESP;
                  end else begin
                     cmd.op   = DP_DEL;
                     state_in = CS_READ;
                  end
               end
               default: begin
                  code_in  = sts.nonempty ? RSP_DONE : RSP_EMPTY;
                  state_in = CS_RESP;
               end
            endcase
         end
         CS_INS_A: begin
            cmd.op   = DP_INS_A;
            state_in = sts.nonempty ? CS_INS_B : CS_RESP;
         end
         CS_INS_B: begin
            cmd.op   = DP_INS_B;
            state_in = CS_RESP;
         end
         CS_READ: begin
            cmd.op   = DP_READ;
            state_in = CS_LOAD;
         end
         CS_LOAD: begin
            cmd.op   = DP_LOAD;
            state_in = CS_RESP;
         end
         CS_RESP: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/clc_dp.sv
// ----------------------------------------------------------------------------
// clc_dp
// Node pool memories, free stack, cursor cache and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module clc_dp #(
   parameter int POOL_NODES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire clc_pkg::req_type req_data,
   input  wire clc_pkg::cmd_type cmd,
   output clc_pkg::sts_type      sts,
   output clc_pkg::rsp_type      rsp_data
);
   import clc_pkg::*;

   localparam int IDX_W = $clog2(POOL_NODES);
   localparam int CNT_W = $clog2(POOL_NODES + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // node storage and free stack
   logic [31:0] data_mem [POOL_NODES];
   idx_type     next_mem [POOL_NODES];
   idx_type     prev_mem [POOL_NODES];
   idx_type     fs_mem   [POOL_NODES];

   logic [31:0] data_rd_ff;
   idx_type     next_rd_ff, prev_rd_ff, fs_rd_ff;

   logic               data_we, next_we, prev_we, fs_we, lk_re, fs_re;
   idx_type            data_wa, next_wa, prev_wa, fs_wa, lk_ra, fs_ra;
   logic [31:0]        data_wd;
   idx_type            next_wd, prev_wd, fs_wd;

   logic [2:0]         mode_ff, mode_in;
   logic signed [31:0] value_ff, value_in;
   idx_type            cursor_ff, cursor_in;
   idx_type            cur_next_ff, cur_next_in;
   idx_type            cur_prev_ff, cur_prev_in;
   logic [31:0]        cur_data_ff, cur_data_in;
   logic               nonempty_ff, nonempty_in;
   cnt_type            len_ff, len_in;
   cnt_type            free_cnt_ff, free_cnt_in;
   cnt_type            low_ff, low_in;
   idx_type            pop_pos_ff, pop_pos_in;
   logic               pop_low_ff, pop_low_in;
   idx_type            new_ff, new_in;
   idx_type            a_ff, a_in;
   idx_type            b_ff, b_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CNT_W+8:0]   cnt_ext;

   always_ff @(posedge clock) begin
      if (data_we) data_mem[data_wa] <= data_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (fs_we)   fs_mem[fs_wa]     <= fs_wd;
      if (lk_re) begin
         data_rd_ff <= data_mem[lk_ra];
         next_rd_ff <= next_mem[lk_ra];
         prev_rd_ff <= prev_mem[lk_ra];
      end
      if (fs_re) fs_rd_ff <= fs_mem[fs_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         nonempty_ff <= 1'b0;
         len_ff      <= '0;
         free_cnt_ff <= cnt_type'(POOL_NODES);
         low_ff      <= cnt_type'(POOL_NODES);
      end else begin
         cursor_ff   <= cursor_in;
         nonempty_ff <= nonempty_in;
         len_ff      <= len_in;
         free_cnt_ff <= free_cnt_in;
         low_ff      <= low_in;
      end
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      cur_next_ff <= cur_next_in;
      cur_prev_ff <= cur_prev_in;
      cur_data_ff <= cur_data_in;
      pop_pos_ff  <= pop_pos_in;
      pop_low_ff  <= pop_low_in;
      new_ff      <= new_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_ff      <= rsp_in;
   end

   assign cnt_ext = {9'd0, len_ff};

   always_comb begin
      idx_type tgt;
      idx_type n;
      idx_type a;
      idx_type b;
      cnt_type pos_w;

      tgt   = '0;
      n     = pop_low_ff ? pop_pos_ff : fs_rd_ff;
      a     = (mode_ff == MODE_INS_AFTER) ? cursor_ff : cur_prev_ff;
      b     = (mode_ff == MODE_INS_AFTER) ? cur_next_ff : cursor_ff;
      pos_w = free_cnt_ff - cnt_type'(1);

      data_we = 1'b0;  data_wa = '0;  data_wd = '0;
      next_we = 1'b0;  next_wa = '0;  next_wd = '0;
      prev_we = 1'b0;  prev_wa = '0;  prev_wd = '0;
      fs_we   = 1'b0;  fs_wa   = '0;  fs_wd   = '0;
      lk_re   = 1'b0;  lk_ra   = '0;
      fs_re   = 1'b0;  fs_ra   = '0;

      mode_in     = mode_ff;
      value_in    = value_ff;
      cursor_in   = cursor_ff;
      cur_next_in = cur_next_ff;
      cur_prev_in = cur_prev_ff;
      cur_data_in = cur_data_ff;
      nonempty_in = nonempty_ff;
      len_in      = len_ff;
      free_cnt_in = free_cnt_ff;
      low_in      = low_ff;
      pop_pos_in  = pop_pos_ff;
      pop_low_in  = pop_low_ff;
      new_in      = new_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      rsp_in      = rsp_ff;

      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_CAPTURE: begin
            mode_in  = req_data.mode;
            value_in = req_data.value;
         end
         DP_MOVE: begin
            tgt       = (mode_ff == MODE_NEXT) ? cur_next_ff : cur_prev_ff;
            lk_re     = 1'b1;
            lk_ra     = tgt;
            cursor_in = tgt;
         end
         DP_POP: begin
            // stack slots below the low-water mark were never written, so their
            // own index is taken in place of the slot's content
            fs_re       = 1'b1;
            fs_ra       = pos_w[IDX_W-1:0];
            pop_pos_in  = pos_w[IDX_W-1:0];
            pop_low_in  = (pos_w < low_ff);
            free_cnt_in = pos_w;
            if (pos_w < low_ff) begin
               low_in = pos_w;
            end
         end
         DP_INS_A: begin
            new_in  = n;
            data_we = 1'b1;
            data_wa = n;
            data_wd = value_ff;
            next_we = 1'b1;
            next_wa = n;
            prev_we = 1'b1;
            prev_wa = n;
            if (!nonempty_ff) begin
               next_wd     = n;
               prev_wd     = n;
               cursor_in   = n;
               cur_next_in = n;
               cur_prev_in = n;
               cur_data_in = value_ff;
               nonempty_in = 1'b1;
               len_in      = cnt_type'(1);
            end else begin
               next_wd = b;
               prev_wd = a;
               a_in    = a;
               b_in    = b;
            end
         end
         DP_INS_B: begin
            next_we = 1'b1;
            next_wa = a_ff;
            next_wd = new_ff;
            prev_we = 1'b1;
            prev_wa = b_ff;
            prev_wd = new_ff;
            if (a_ff == cursor_ff) begin
               cur_next_in = new_ff;
            end
            if (b_ff == cursor_ff) begin
               cur_prev_in = new_ff;
            end
            len_in = len_ff + cnt_type'(1);
         end
         DP_DEL_ONE: begin
            fs_we       = 1'b1;
            fs_wa       = free_cnt_ff[IDX_W-1:0];
            fs_wd       = cursor_ff;
            free_cnt_in = free_cnt_ff + cnt_type'(1);
            nonempty_in = 1'b0;
            len_in      = '0;
            cursor_in   = '0;
         end
         DP_DEL: begin
            next_we     = 1'b1;
            next_wa     = cur_prev_ff;
            next_wd     = cur_next_ff;
            prev_we     = 1'b1;
            prev_wa     = cur_next_ff;
            prev_wd     = cur_prev_ff;
            fs_we       = 1'b1;
            fs_wa       = free_cnt_ff[IDX_W-1:0];
            fs_wd       = cursor_ff;
            free_cnt_in = free_cnt_ff + cnt_type'(1);
            cursor_in   = (mode_ff == MODE_DEL_NEXT) ? cur_next_ff : cur_prev_ff;
            len_in      = len_ff - cnt_type'(1);
         end
         DP_READ: begin
            lk_re = 1'b1;
            lk_ra = cursor_ff;
         end
         DP_LOAD: begin
            cur_next_in = next_rd_ff;
            cur_prev_in = prev_rd_ff;
            cur_data_in = data_rd_ff;
         end
         DP_RESP: begin
            rsp_in.status       = cmd.code;
            rsp_in.cursor_valid = nonempty_ff;
            rsp_in.cursor_value = nonempty_ff ? cur_data_ff : 32'd0;
            rsp_in.count        = cnt_ext[8:0];
         end
         default: begin
         end
      endcase
   end

   assign sts.mode     = mode_ff;
   assign sts.nonempty = nonempty_ff;
   assign sts.full     = (free_cnt_ff == '0);
   assign sts.single   = (len_ff == cnt_type'(1));
   assign rsp_data     = rsp_ff;

endmodule

`default_nettype wire

FILE: src/circular_list_with_cursor.sv
// ----------------------------------------------------------------------------
// circular_list_with_cursor
// Circular doubly linked list of signed 32-bit values with a cursor.
// ----------------------------------------------------------------------------
//   req channel: one transaction names an operation (move next/prev, insert
//   after/before the cursor, delete the cursor's node stepping next/prev)
//   and, for inserts, the value to store.
//   rsp channel: exactly one transaction per request, carrying the status,
//   the cursor's value (zero when the list is empty) and the list length.
//   One request is in work at a time. It is decoded first; a refused
//   insert, a no-op, an empty-list move or delete, or a delete of the
//   only node then goes straight to the response. A move reloads the
//   cursor; an insert writes the new node and, if the list was not empty,
//   links it in; a delete unlinks the node and reloads the new cursor.
//   Each link update is one write, each cursor reload a registered read.
//   A finished response sits in an output register, so the next request is
//   taken while the receiver stalls; a second response waits until that
//   register drains. Reset empties the list and refills the free pool at
//   once, with no clearing pass; node storage is left unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_with_cursor #(
   parameter int POOL_NODES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire clc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output clc_pkg::rsp_type      rsp_data
);
   import clc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   clc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   clc_dp #(
      .POOL_NODES (POOL_NODES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

FILE: src/clc_checker.sv
// ----------------------------------------------------------------------------
// clc_checker
// Port-level checks for the circular list with cursor block.
// ----------------------------------------------------------------------------
`default_nettype none

module clc_checker #(
   parameter int POOL_NODES = 256
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire clc_pkg::rsp_type rsp_data
);
   import clc_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one transaction in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.cursor_valid |-> rsp_data.cursor_value == 32'sd0)
      else $error("empty list reports a cursor value");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (POOL_NODES < 512) |->
         (rsp_data.cursor_valid == (rsp_data.count != 9'd0)))
      else $error("cursor_valid disagrees with count");

   // a refused insert only happens on a full, hence non-empty, list
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == RSP_FULL |-> rsp_data.cursor_valid)
      else $error("pool full reported on an empty list");

endmodule

bind circular_list_with_cursor clc_checker #(.POOL_NODES(POOL_NODES)) u_clc_checker (.*);

`default_nettype wire
